// ===== rtl/cutd_pkg.sv =====
// Shared types and constants for the CPU utilization target decision block.
// Used by cutd_front, cutd_queue, cutd_back and cpu_util_target_decision.
// No dependencies.
package cutd_pkg;

  localparam int NUM_CLUSTERS = 3;
  localparam int NUM_BOOSTS   = 3;  // boost inputs on the request
  localparam int NUM_WEIGHTS  = 3;  // blend weight registers
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [30:0] NO_LIMIT    = 31'h7FFF_FFFF;
  localparam logic [6:0]  WEIGHT_FULL = 7'd100;

  // request action codes
  localparam logic [2:0] ACT_SET_CEIL  = 3'd0;
  localparam logic [2:0] ACT_SET_BOOST = 3'd1;
  localparam logic [2:0] ACT_SET_VOTE  = 3'd2;
  localparam logic [2:0] ACT_DECIDE    = 3'd3;
  localparam logic [2:0] ACT_READ_VOTE = 3'd4;
  localparam logic [2:0] ACT_CLEAR     = 3'd5;

  typedef enum logic [1:0] {
    OP_CONST,    // answer is the value field as is
    OP_NOLIMIT,  // decide without a ceiling
    OP_LIMIT     // decide with ceiling-derived target
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic [15:0] util;
    logic [30:0] cluster_fmax;
    logic [15:0] util_scale;
    logic [30:0] ceiling;
    logic [7:0]  boost;
    logic [6:0]  weight;
  } entry_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_EX1,
    BK_EX2,
    BK_BL1,
    BK_BL2,
    BK_BL3,
    BK_BL4,
    BK_BL5,
    BK_FIN,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic idle;     // back end waits for a queue entry
    logic holding;  // finished result waits for the output register
  } bk_status_t;

endpackage

// ===== rtl/cpu_util_target_decision.sv =====
// Top level of the CPU utilization target decision block.
// Depends on cutd_pkg, cutd_front, cutd_queue and cutd_back.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    action, cluster, util, cluster_fmax,
//                                            util_scale, limit_max, boost_*,
//                                            bus_vote_value
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//   out      source     out_valid/out_ready  result_value
//
// Back-end steps: decide with a ceiling runs a 47-step serial divide plus eleven
// load, multiply, compare and output steps, skipping the later blend steps at
// blend weight zero; a ceiling-free decide skips divide and blend; others output.
// The front accepts a request per cycle while the two-entry queue has room.
// Synchronous reset clears stores, vote and queue and loads every weight with 100.
// A stalled output holds one result in the output register and one in the back end.
module cpu_util_target_decision import cutd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [1:0]  cluster,
  input  logic [15:0] util,
  input  logic [30:0] cluster_fmax,
  input  logic [15:0] util_scale,
  input  logic [30:0] limit_max,
  input  logic [7:0]  boost_first,
  input  logic [7:0]  boost_second,
  input  logic [7:0]  boost_third,
  input  logic [31:0] bus_vote_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic       room;
  logic       push;
  entry_t     wr_entry;
  logic       q_valid;
  logic       q_pop;
  entry_t     rd_entry;
  logic [1:0] q_count;
  bk_status_t bk_status;

  cutd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .cluster        (cluster),
    .util           (util),
    .cluster_fmax   (cluster_fmax),
    .util_scale     (util_scale),
    .limit_max      (limit_max),
    .boost_first    (boost_first),
    .boost_second   (boost_second),
    .boost_third    (boost_third),
    .bus_vote_value (bus_vote_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .room           (room),
    .push           (push),
    .entry          (wr_entry)
  );

  cutd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .room     (room),
    .pop      (q_pop),
    .valid    (q_valid),
    .rd_entry (rd_entry),
    .count    (q_count)
  );

  cutd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (rd_entry),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (bk_status)
  );

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= 2'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a new result only comes from a back end that was working on a request
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!bk_status.idle))
    else $error("result without a request in the back end");

  // a waiting result is not dropped while the output stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && bk_status.holding |=> bk_status.holding)
    else $error("waiting result lost during output stall");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && q_count == 2'd0)
    else $error("output or queue not empty after reset");

endmodule

// ===== rtl/cutd_front.sv =====
// Front end: accepts requests, keeps ceilings, boosts, vote and blend weights,
// and turns each request into a self-contained queue entry.
// Depends on cutd_pkg.
module cutd_front import cutd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [1:0]  cluster,
  input  logic [15:0] util,
  input  logic [30:0] cluster_fmax,
  input  logic [15:0] util_scale,
  input  logic [30:0] limit_max,
  input  logic [7:0]  boost_first,
  input  logic [7:0]  boost_second,
  input  logic [7:0]  boost_third,
  input  logic [31:0] bus_vote_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        room,
  output logic        push,
  output entry_t      entry
);

  logic [30:0] ceiling [NUM_CLUSTERS];
  logic [7:0]  boost   [NUM_CLUSTERS];
  logic [6:0]  weight  [NUM_CLUSTERS];
  logic [7:0]  boost_in [NUM_BOOSTS];
  logic [31:0] vote;

  logic [30:0] sel_ceil;
  logic [7:0]  sel_boost;
  logic [6:0]  sel_weight;
  logic        in_range;

  assign in_ready  = room;
  assign cfg_ready = 1'b1;
  assign push      = in_valid && room;

  assign boost_in[0] = boost_first;
  assign boost_in[1] = boost_second;
  assign boost_in[2] = boost_third;

  for (genvar g = 0; g < NUM_CLUSTERS; g++) begin : g_cl
    always_ff @(posedge clk) begin
      if (rst) begin
        ceiling[g] <= '0;
      end else if (push) begin
        if (action == ACT_CLEAR) begin
          ceiling[g] <= '0;
        end else if (action == ACT_SET_CEIL && int'(cluster) == g) begin
          ceiling[g] <= limit_max;
        end
      end
    end

    if (g < NUM_BOOSTS) begin : g_boost
      always_ff @(posedge clk) begin
        if (rst) begin
          boost[g] <= '0;
        end else if (push) begin
          if (action == ACT_CLEAR) begin
            boost[g] <= '0;
          end else if (action == ACT_SET_BOOST) begin
            boost[g] <= boost_in[g];
          end
        end
      end
    end else begin : g_noboost
      assign boost[g] = '0;
    end

    if (g < NUM_WEIGHTS) begin : g_wt
      always_ff @(posedge clk) begin
        if (rst) begin
          weight[g] <= WEIGHT_FULL;
        end else if (cfg_valid && int'(cfg_index) == g) begin
          weight[g] <= cfg_data;
        end
      end
    end else begin : g_nowt
      assign weight[g] = WEIGHT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vote <= '0;
    end else if (push) begin
      if (action == ACT_CLEAR) begin
        vote <= '0;
      end else if (action == ACT_SET_VOTE) begin
        vote <= bus_vote_value;
      end
    end
  end

  always_comb begin
    sel_ceil   = '0;
    sel_boost  = '0;
    sel_weight = WEIGHT_FULL;
    for (int i = 0; i < NUM_CLUSTERS; i++) begin
      if (int'(cluster) == i) begin
        sel_ceil   = ceiling[i];
        sel_boost  = boost[i];
        sel_weight = weight[i];
      end
    end
  end

  assign in_range = int'(cluster) < NUM_CLUSTERS;

  // state is sampled here so queued decides see it in request order
  always_comb begin
    entry.op           = OP_CONST;
    entry.value        = '0;
    entry.util         = util;
    entry.cluster_fmax = cluster_fmax;
    entry.util_scale   = util_scale;
    entry.ceiling      = sel_ceil;
    entry.boost        = sel_boost;
    entry.weight       = (sel_weight > WEIGHT_FULL) ? WEIGHT_FULL : sel_weight;
    priority case (action)
      ACT_DECIDE: begin
        if (!in_range) begin
          entry.value = {16'd0, util};
        end else if (sel_ceil == '0 || sel_ceil == NO_LIMIT) begin
          entry.op = OP_NOLIMIT;
        end else begin
          entry.op = OP_LIMIT;
        end
      end
      ACT_READ_VOTE: entry.value = vote;
      default: entry.value = '0;
    endcase
  end

endmodule

// ===== rtl/cutd_queue.sv =====
// Two-entry queue between front and back end.
// Depends on cutd_pkg.
module cutd_queue import cutd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  entry_t     wr_entry,
  output logic       room,
  input  logic       pop,
  output logic       valid,
  output entry_t     rd_entry,
  output logic [1:0] count
);

  entry_t slots [QUEUE_DEPTH];
  logic   wr_ptr;
  logic   rd_ptr;
  logic   do_pop;

  assign room     = count != 2'(QUEUE_DEPTH);
  assign valid    = count != 2'd0;
  assign do_pop   = pop && valid;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/cutd_back.sv =====
// Back end: runs one queue entry at a time through a sequencer with a
// bit-serial divider and reciprocal multiply steps, then an output register.
// Depends on cutd_pkg.
module cutd_back import cutd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output bk_status_t  status
);

  // floor(x/d) = (x * ceil(2^s/d)) >> s, exact over the noted input range
  localparam logic [23:0] RECIP_10  = 24'd13421773;     // x < 2^24, s = 27
  localparam logic [23:0] RECIP_5   = 24'd13421773;     // x < 2^26, s = 26
  localparam logic [31:0] RECIP_100 = 32'd2748779070;   // x < 2^31, s = 38
  localparam logic [23:0] T_CLAMP   = 24'h7F_FFFF;

  bk_state_t   state, state_next;
  entry_t      e;
  logic [23:0] prod_bm;
  logic [46:0] dq;
  logic [30:0] rem;
  logic [5:0]  cnt;
  logic [20:0] q10;
  logic [20:0] extra;
  logic [22:0] pa;
  logic [30:0] pb;
  logic [15:0] qa;
  logic [22:0] qb;
  logic [25:0] sum4;
  logic [23:0] t;
  logic [31:0] result;

  logic [30:0] mf;
  logic [31:0] trial;
  logic [31:0] diff;
  logic        ge;
  logic [23:0] tc;
  logic [47:0] m10;
  logic [46:0] m5x;
  logic [49:0] m5s;
  logic [62:0] ma;
  logic [62:0] mb;
  logic [15:0] mn;
  logic [21:0] sum_r;
  logic [15:0] capped;
  logic        load_out;

  assign load_out = (state == BK_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop = 1'b1;
        if (q_valid) begin
          state_next = (q_entry.op == OP_CONST) ? BK_OUT : BK_MUL;
        end
      end
      BK_MUL: state_next = (e.op == OP_LIMIT) ? BK_DIV : BK_EX1;
      BK_DIV: if (cnt == 6'd0) state_next = BK_EX1;
      BK_EX1: state_next = BK_EX2;
      BK_EX2: state_next = (e.op == OP_LIMIT) ? BK_BL1 : BK_FIN;
      BK_BL1: state_next = (e.weight == 7'd0) ? BK_FIN : BK_BL2;
      BK_BL2: state_next = BK_BL3;
      BK_BL3: state_next = BK_BL4;
      BK_BL4: state_next = BK_BL5;
      BK_BL5: state_next = BK_FIN;
      BK_FIN: state_next = BK_OUT;
      BK_OUT: if (load_out) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  assign status.idle    = state == BK_IDLE;
  assign status.holding = state == BK_OUT;

  // datapath helpers
  assign mf    = (e.cluster_fmax == '0) ? 31'd1 : e.cluster_fmax;
  assign trial = {rem, dq[46]};
  assign ge    = trial >= {1'b0, mf};
  assign diff  = trial - {1'b0, mf};
  // a target this large already puts the blend above any util
  assign tc    = (dq[46:23] != '0) ? T_CLAMP : {1'b0, dq[22:0]};
  assign m10   = {24'd0, prod_bm} * {24'd0, RECIP_10};
  assign m5x   = {24'd0, q10, 2'b00} * {23'd0, RECIP_5};
  assign m5s   = {24'd0, sum4} * {26'd0, RECIP_5};
  assign ma    = {40'd0, pa} * {31'd0, RECIP_100};
  assign mb    = {32'd0, pb} * {31'd0, RECIP_100};
  assign mn    = (e.op == OP_NOLIMIT || t >= {8'd0, e.util}) ? e.util : t[15:0];
  assign sum_r = {6'd0, mn} + {1'b0, extra};
  assign capped = (sum_r > {6'd0, e.util_scale}) ? e.util_scale : sum_r[15:0];

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          e      <= q_entry;
          result <= q_entry.value;
        end
      end
      BK_MUL: begin
        prod_bm <= {16'd0, e.boost} * {8'd0, e.util_scale};
        dq      <= {16'd0, e.ceiling} * {31'd0, e.util_scale};
        rem     <= '0;
        cnt     <= 6'd46;
      end
      BK_DIV: begin
        rem <= ge ? diff[30:0] : trial[30:0];
        dq  <= {dq[45:0], ge};
        cnt <= cnt - 6'd1;
      end
      BK_EX1: q10   <= m10[47:27];
      BK_EX2: extra <= m5x[46:26];
      BK_BL1: begin
        t  <= tc;
        pa <= {7'd0, e.util} * {16'd0, WEIGHT_FULL - e.weight};
        pb <= {7'd0, tc} * {24'd0, e.weight};
      end
      BK_BL2: qa <= ma[53:38];
      BK_BL3: qb <= mb[60:38];
      BK_BL4: sum4 <= {({8'd0, qa} + {1'b0, qb}), 2'b00};
      BK_BL5: t <= {1'b0, m5s[48:26]};
      BK_FIN: result <= {16'd0, capped};
      BK_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_value <= result;
    end
  end

endmodule
